### sv/gfcd_pkg.sv
// ----------------------------------------------------------------------------
// gfcd_pkg: shared types and constants for the gated frequency counter
// Beat payload structures, configuration register indexes and the
// seven-segment decoder used by the display scan.
// ----------------------------------------------------------------------------
package gfcd_pkg;

    localparam int CFG_DATA_W = 17;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_GATE_PERIOD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GATE_REPEATS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DWELL_ITEMS  = 2'd2;

    localparam logic [16:0] GATE_PERIOD_RST  = 17'd62500;
    localparam logic [4:0]  GATE_REPEATS_RST = 5'd5;
    localparam logic [15:0] DWELL_ITEMS_RST  = 16'd120;

    // Largest number of sub-periods in one gate window.
    localparam logic [4:0]  REPEATS_MAX      = 5'd16;
    localparam logic [3:0]  DECADE_MAX       = 4'd9;

    typedef struct packed {
        logic pulse_edge;
        logic timebase_tick;
    } gfcd_in_t;

    typedef struct packed {
        logic [6:0] segments;
        logic [7:0] digit_enable;
        logic       measure_done;
        logic       over_range;
    } gfcd_out_t;

    // Segment a is bit 0. Codes that are not decimal digits stay dark.
    function automatic logic [6:0] seg_decode(input logic [3:0] digit);
        logic [6:0] seg;
        case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

### sv/gfcd_decade_counter.sv
// ----------------------------------------------------------------------------
// gfcd_decade_counter: saturating BCD edge counter
// Holds the live decade digits and the overflow flag of the running gate
// window. The value after the current beat's edge is offered combinationally
// so that the caller can latch it on the beat that closes the window.
// ----------------------------------------------------------------------------
module gfcd_decade_counter
    import gfcd_pkg::*;
#(
    parameter int DIGITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic                   edge_in,
    input  logic                   clear,
    output logic [DIGITS-1:0][3:0] count_digits,
    output logic                   count_overflow
);

    logic [DIGITS-1:0][3:0] live_reg;
    logic                   ovf_reg;
    logic [DIGITS-1:0][3:0] inc_digits;
    logic                   all_nine;

    // Ripple carry: a digit advances when every lower digit is at nine.
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int k = 0; k < DIGITS; k++) begin
            if (carry) begin
                inc_digits[k] = (live_reg[k] == DECADE_MAX) ? 4'd0 : live_reg[k] + 4'd1;
            end else begin
                inc_digits[k] = live_reg[k];
            end
            carry = carry & (live_reg[k] == DECADE_MAX);
        end
        all_nine = carry;
    end

    always_comb begin
        count_digits   = live_reg;
        count_overflow = ovf_reg;
        if (edge_in) begin
            if (all_nine) begin
                count_overflow = 1'b1;
            end else begin
                count_digits = inc_digits;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
            ovf_reg  <= 1'b0;
        end else if (step) begin
            if (clear) begin
                live_reg <= '0;
                ovf_reg  <= 1'b0;
            end else begin
                live_reg <= count_digits;
                ovf_reg  <= count_overflow;
            end
        end
    end

endmodule

### sv/gated_frequency_counter_display.sv
// ----------------------------------------------------------------------------
// gated_frequency_counter_display: gated frequency counter with display scan
// Counts measured edges in decade digits over a timebase gate window and
// drives a multiplexed seven-segment display from the latched count.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one beat per clock of the measured system: a flag
//   for a rising edge of the measured signal and a flag for a timebase tick.
//   Every accepted beat yields exactly one m_ beat carrying the segment
//   pattern and one-hot enable of the scanned digit, a measure_done strobe
//   on the beat that closes a gate window, and the latched over_range flag.
//   The result of a beat is registered and valid on m_ in the cycle after
//   it is accepted. Throughput is one beat per cycle while the receiver
//   accepts; the counters update in a single pass of logic between the
//   input handshake and the output register.
//   When the receiver stalls, the output register holds its beat and s_ready
//   stays high only while that register is empty or being emptied.
//   Reset (aresetn low, synchronous) clears all counts, the displayed digits
//   and flags, and loads the registers with their defaults. The cfg_ port
//   writes gate_period, gate_repeats and dwell_items; write only while idle.
// ----------------------------------------------------------------------------
module gated_frequency_counter_display
    import gfcd_pkg::*;
#(
    parameter int DIGITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gfcd_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gfcd_out_t             m_data
);

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IDX_W:0] DIGITS_N = (IDX_W + 1)'(DIGITS);

    logic [16:0] gate_period_reg;
    logic [4:0]  gate_repeats_reg;
    logic [15:0] dwell_items_reg;

    logic [16:0]      tick_reg,  tick_next;
    logic [3:0]       sub_reg,   sub_next;
    logic [15:0]      dwell_reg, dwell_next;
    logic [IDX_W-1:0] scan_reg,  scan_next;

    logic [DIGITS-1:0][3:0] shown_reg, shown_next;
    logic                   shown_ovf_reg, shown_ovf_next;

    logic      m_valid_reg;
    gfcd_out_t m_data_reg, m_data_next;

    logic                   accept;
    logic                   window_close;
    logic [DIGITS-1:0][3:0] count_digits;
    logic                   count_overflow;

    logic [16:0] period_eff;
    logic [4:0]  repeats_eff;
    logic [15:0] dwell_eff;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_period_reg  <= GATE_PERIOD_RST;
            gate_repeats_reg <= GATE_REPEATS_RST;
            dwell_items_reg  <= DWELL_ITEMS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_GATE_PERIOD:  gate_period_reg  <= cfg_wdata;
                CFG_GATE_REPEATS: gate_repeats_reg <= cfg_wdata[4:0];
                CFG_DWELL_ITEMS:  dwell_items_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // A zero register acts as one; more than sixteen repeats act as sixteen.
    always_comb begin
        period_eff  = (gate_period_reg == '0) ? 17'd1 : gate_period_reg;
        dwell_eff   = (dwell_items_reg == '0) ? 16'd1 : dwell_items_reg;
        if (gate_repeats_reg == '0) begin
            repeats_eff = 5'd1;
        end else if (gate_repeats_reg > REPEATS_MAX) begin
            repeats_eff = REPEATS_MAX;
        end else begin
            repeats_eff = gate_repeats_reg;
        end
    end

    gfcd_decade_counter #(
        .DIGITS (DIGITS)
    ) u_counter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (accept),
        .edge_in        (s_data.pulse_edge),
        .clear          (window_close),
        .count_digits   (count_digits),
        .count_overflow (count_overflow)
    );

    // Gate timing: ticks build sub-periods, sub-periods build the window.
    always_comb begin
        tick_next      = tick_reg;
        sub_next       = sub_reg;
        window_close   = 1'b0;
        shown_next     = shown_reg;
        shown_ovf_next = shown_ovf_reg;
        if (s_data.timebase_tick) begin
            if ({1'b0, tick_reg} + 18'd1 >= {1'b0, period_eff}) begin
                tick_next = '0;
                if ({1'b0, sub_reg} + 5'd1 >= repeats_eff) begin
                    sub_next       = '0;
                    window_close   = 1'b1;
                    shown_next     = count_digits;
                    shown_ovf_next = count_overflow;
                end else begin
                    sub_next = sub_reg + 4'd1;
                end
            end else begin
                tick_next = tick_reg + 17'd1;
            end
        end
    end

    // Display scan.
    always_comb begin
        dwell_next = dwell_reg;
        scan_next  = scan_reg;
        if ({1'b0, dwell_reg} + 17'd1 >= {1'b0, dwell_eff}) begin
            dwell_next = '0;
            if ({1'b0, scan_reg} + (IDX_W + 1)'(1) >= DIGITS_N) begin
                scan_next = '0;
            end else begin
                scan_next = scan_reg + IDX_W'(1);
            end
        end else begin
            dwell_next = dwell_reg + 16'd1;
        end
    end

    always_comb begin
        m_data_next.segments     = seg_decode(shown_next[scan_next]);
        m_data_next.digit_enable = '0;
        if (int'(scan_next) < 8) begin
            m_data_next.digit_enable = 8'd1 << scan_next;
        end
        m_data_next.measure_done = window_close;
        m_data_next.over_range   = shown_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            sub_reg       <= '0;
            dwell_reg     <= '0;
            scan_reg      <= '0;
            shown_reg     <= '0;
            shown_ovf_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                tick_reg      <= tick_next;
                sub_reg       <= sub_next;
                dwell_reg     <= dwell_next;
                scan_reg      <= scan_next;
                shown_reg     <= shown_next;
                shown_ovf_reg <= shown_ovf_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
